>>> rtl/core/ahcp_pkg.sv
// ============================================================================
// ahcp_pkg
// Shared types and constants for the ASCII hex CAN frame parser.
// ============================================================================
package ahcp_pkg;

    localparam logic [7:0] CHAR_T  = 8'h74;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    localparam int ID_DIGITS  = 3;
    localparam int CNT_W      = 5;
    localparam int ID_W       = 12;
    localparam int LEN_W      = 4;
    localparam int FRAME_BYTES = 8;

    typedef struct packed {
        logic [ID_W-1:0]               id;
        logic [LEN_W-1:0]              len;
        logic [FRAME_BYTES-1:0][7:0]   data;
    } frame_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

>>> rtl/core/ahcp_parser.sv
// ============================================================================
// ahcp_parser
// Phase tracking, digit capture and frame assembly for one character beat.
// ============================================================================
module ahcp_parser #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       item_char,
    output logic             is_newline,
    output ahcp_pkg::frame_t frame
);
    import ahcp_pkg::*;

    localparam int NIB_NUM   = 2 * MAX_DATA_BYTES;
    localparam int NIB_IDX_W = (NIB_NUM > 1) ? $clog2(NIB_NUM) : 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       nib_reg [NIB_NUM];
    logic             nib_we;
    logic [3:0]       digit;
    logic [CNT_W-1:0] count_eff;
    logic [7:0]       byte_w [FRAME_BYTES];

    assign digit      = hex_value(item_char);
    assign is_newline = (item_char == CHAR_NL);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        nib_we     = 1'b0;
        if (advance)
        begin
            if (item_char == CHAR_NL)
            begin
                phase_next = PH_IDLE;
                count_next = '0;
                id_next    = '0;
                len_next   = '0;
            end
            else if (item_char == CHAR_T)
            begin
                phase_next = PH_ID;
                count_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_ID:
                    begin
                        case (count_reg[1:0])
                            2'd0:    id_next[11:8] = digit;
                            2'd1:    id_next[7:4]  = digit;
                            default: id_next[3:0]  = digit;
                        endcase
                        if (count_reg == CNT_W'(ID_DIGITS - 1))
                        begin
                            count_next = '0;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    PH_LEN:
                    begin
                        len_next   = digit;
                        count_next = '0;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (count_reg < CNT_W'(NIB_NUM))
                        begin
                            nib_we     = 1'b1;
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
        end
    end

    // hold data nibbles; entries at or above the digit count are masked on read
    always_ff @(posedge clk)
    begin
        if (nib_we)
        begin
            nib_reg[count_reg[NIB_IDX_W-1:0]] <= digit;
        end
    end

    assign count_eff = (phase_reg == PH_DATA) ? count_reg : '0;

    for (genvar i = 0; i < FRAME_BYTES; i++)
    begin : g_byte
        if (i < MAX_DATA_BYTES)
        begin : g_live
            assign byte_w[i] = {
                (count_eff > CNT_W'(2 * i))     ? nib_reg[2 * i]     : 4'h0,
                (count_eff > CNT_W'(2 * i + 1)) ? nib_reg[2 * i + 1] : 4'h0
            };
        end
        else
        begin : g_zero
            assign byte_w[i] = 8'h00;
        end
    end

    always_comb
    begin
        frame.id  = id_reg;
        frame.len = len_reg;
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            frame.data[k] = byte_w[k];
        end
    end

endmodule

>>> rtl/core/ahcp_out_reg.sv
// ============================================================================
// ahcp_out_reg
// Result register holding one assembled frame until the output beat is taken.
// ============================================================================
module ahcp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ahcp_pkg::frame_t frame_in,
    input  logic             out_stall,
    output logic             out_valid,
    output ahcp_pkg::frame_t frame_out
);
    import ahcp_pkg::*;

    logic   valid_reg, valid_next;
    frame_t frame_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_in;
        end
    end

    assign out_valid = valid_reg;
    assign frame_out = frame_reg;

endmodule

>>> rtl/core/ascii_hex_can_frame_parser.sv
// An accepted newline is registered at the input, then its frame loads the out_valid register.
// Throughput: one character per cycle; a newline waits only while a frame beat is stalled.
// in_stall rises only when a newline is held and the output register is full and stalled.
// Reset (rst_n low, asynchronous) clears the phase, digit count, identifier, length and valids.
// ============================================================================
// ascii_hex_can_frame_parser
// ASCII CAN line parser: 't', three identifier digits, one length digit,
// up to sixteen data digits; a newline emits one frame.
// ============================================================================
module ascii_hex_can_frame_parser #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_char,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ahcp_pkg::ID_W-1:0]   frame_id,
    output logic [ahcp_pkg::LEN_W-1:0]  frame_len,
    output logic [7:0]                  byte0,
    output logic [7:0]                  byte1,
    output logic [7:0]                  byte2,
    output logic [7:0]                  byte3,
    output logic [7:0]                  byte4,
    output logic [7:0]                  byte5,
    output logic [7:0]                  byte6,
    output logic [7:0]                  byte7
);
    import ahcp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       advance;
    logic       is_newline;
    logic       out_free;
    frame_t     frame_asm;
    frame_t     frame_out;

    // drop the held beat into the parser unless a newline meets a full, stalled output
    assign out_free      = !out_valid || !out_stall;
    assign advance       = in_valid_reg && (!is_newline || out_free);
    assign in_stall      = in_valid_reg && !advance;
    assign in_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= rx_char;
        end
    end

    ahcp_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_char  (char_reg),
        .is_newline (is_newline),
        .frame      (frame_asm)
    );

    ahcp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && is_newline),
        .frame_in  (frame_asm),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .frame_out (frame_out)
    );

    assign frame_id  = frame_out.id;
    assign frame_len = frame_out.len;
    assign byte0     = frame_out.data[0];
    assign byte1     = frame_out.data[1];
    assign byte2     = frame_out.data[2];
    assign byte3     = frame_out.data[3];
    assign byte4     = frame_out.data[4];
    assign byte5     = frame_out.data[5];
    assign byte6     = frame_out.data[6];
    assign byte7     = frame_out.data[7];

endmodule

>>> rtl/core/ahcp_checker.sv
// ============================================================================
// ahcp_checker
// Port-level checks on the parser's beat flow, bound to the top level.
// ============================================================================
module ahcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_char,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] frame_id
);
    import ahcp_pkg::*;

    logic nl_beat;
    logic other_beat;

    assign nl_beat    = in_valid && !in_stall && (rx_char == CHAR_NL);
    assign other_beat = in_valid && !in_stall && (rx_char != CHAR_NL);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_id))
        else $error("stalled frame beat changed or vanished");

    a_nl_emits: assert property (@(posedge clk) disable iff (!rst_n)
        nl_beat |-> ##2 out_valid)
        else $error("newline beat produced no frame beat");

    a_rose_from_nl: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(nl_beat, 2))
        else $error("frame beat without a newline beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_char_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        other_beat |=> !in_stall)
        else $error("non-newline beat caused a stall");

endmodule

bind ascii_hex_can_frame_parser ahcp_checker u_ahcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_char   (rx_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_id  (frame_id)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench for the ASCII hex CAN frame parser. A driver sends serial
// characters from a queue. A built-in line parser predicts every emitted
// frame, and a monitor compares each frame field by field while both sides
// idle and stall at random.
// ============================================================================
module tb_top;

    import ahcp_pkg::*;

    localparam int MAX_BYTES      = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;

    typedef enum logic [1:0] {LP_IDLE, LP_ID, LP_LEN, LP_DATA} line_phase_e;

    typedef struct {
        bit         drain;
        logic [7:0] ch;
    } line_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_char = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [ID_W-1:0]  frame_id;
    logic [LEN_W-1:0] frame_len;
    logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;

    line_beat_t line_q[$];
    frame_t     frame_q[$];

    // line parser state
    line_phase_e      ln_phase = LP_IDLE;
    int               ln_count = 0;
    logic [ID_W-1:0]  ln_id = '0;
    logic [LEN_W-1:0] ln_len = '0;
    logic [3:0]       ln_nib [16] = '{default: 4'h0};

    int  err_count = 0;
    int  stim_items = 0;
    bit  stim_done = 1'b0;
    int  gap_left = 0;
    int  send_beats = 0;
    bit  send_quiet = 1'b0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  out_cycles = 0;
    bit  out_quiet = 1'b0;
    int  frames_seen = 0;

    ascii_hex_can_frame_parser #(
        .MAX_DATA_BYTES (MAX_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_char   (rx_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .frame_id  (frame_id),
        .frame_len (frame_len),
        .byte0     (byte0),
        .byte1     (byte1),
        .byte2     (byte2),
        .byte3     (byte3),
        .byte4     (byte4),
        .byte5     (byte5),
        .byte6     (byte6),
        .byte7     (byte7)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 4'(c - 8'h30);
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return 4'(c - 8'h57);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c - 8'h37);
        end
        return 4'h0;
    endfunction

    function automatic bit take_char(input logic [7:0] c, output frame_t f);
        logic [3:0] v;
        int n;
        int i;
        v = digit_of(c);
        f = '0;
        if (c == CHAR_NL)
        begin
            n = (ln_phase == LP_DATA) ? ln_count : 0;
            f.id  = ln_id;
            f.len = ln_len;
            for (i = 0; i < FRAME_BYTES; i++)
            begin
                if (i < MAX_BYTES && 2 * i < n)
                begin
                    f.data[i] = {ln_nib[2 * i], 4'h0};
                    if (2 * i + 1 < n)
                    begin
                        f.data[i][3:0] = ln_nib[2 * i + 1];
                    end
                end
            end
            ln_phase = LP_IDLE;
            ln_count = 0;
            ln_id    = '0;
            ln_len   = '0;
            ln_nib   = '{default: 4'h0};
            return 1'b1;
        end
        if (c == CHAR_T)
        begin
            ln_phase = LP_ID;
            ln_count = 0;
            return 1'b0;
        end
        case (ln_phase)
            LP_ID:
            begin
                ln_id[(11 - 4 * (ln_count % ID_DIGITS)) -: 4] = v;
                ln_count++;
                if (ln_count >= ID_DIGITS)
                begin
                    ln_count = 0;
                    ln_phase = LP_LEN;
                end
            end
            LP_LEN:
            begin
                ln_len   = v;
                ln_count = 0;
                ln_phase = LP_DATA;
            end
            LP_DATA:
            begin
                if (ln_count < 2 * MAX_BYTES && ln_count < 16)
                begin
                    ln_nib[ln_count] = v;
                    ln_count++;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic push_char(input logic [7:0] c, input bit counted);
        line_beat_t b;
        b.drain = 1'b0;
        b.ch    = c;
        line_q.push_back(b);
        if (counted)
        begin
            stim_items++;
        end
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            push_char(s[k], 1'b1);
        end
    endtask

    task automatic push_drain();
        line_beat_t b;
        b.drain = 1'b1;
        b.ch    = 8'h00;
        line_q.push_back(b);
    endtask

    function automatic logic [7:0] frame_digit();
        int v;
        if ($urandom_range(0, 9) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return $urandom_range(0, 1) ? 8'(8'h57 + v) : 8'(8'h37 + v);
    endfunction

    task automatic add_line();
        int kind;
        int n;
        int k;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            // idle noise, ignored by the block
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
            begin
                c = 8'($urandom_range(0, 255));
                if (c != CHAR_T && c != CHAR_NL)
                begin
                    push_char(c, 1'b0);
                end
            end
            return;
        end
        if (kind < 12)
        begin
            push_char(CHAR_T, 1'b1);
            n = $urandom_range(1, 20);
            for (k = 0; k < n; k++)
            begin
                push_char(8'($urandom_range(0, 255)), 1'b1);
            end
            push_char(CHAR_NL, 1'b1);
            return;
        end
        if (kind < 30)
        begin
            // cut short, sometimes after a restart
            if ($urandom_range(0, 1))
            begin
                push_char(CHAR_T, 1'b1);
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                begin
                    push_char(frame_digit(), 1'b1);
                end
            end
            push_char(CHAR_T, 1'b1);
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++)
            begin
                push_char(frame_digit(), 1'b1);
            end
            push_char(CHAR_NL, 1'b1);
            return;
        end
        if (kind < 37)
        begin
            push_char(CHAR_T, 1'b1);
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++)
            begin
                push_char(frame_digit(), 1'b1);
            end
        end
        push_char(CHAR_T, 1'b1);
        for (k = 0; k < ID_DIGITS + 1; k++)
        begin
            push_char(frame_digit(), 1'b1);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 16);
        for (k = 0; k < n; k++)
        begin
            push_char(frame_digit(), 1'b1);
        end
        push_char(CHAR_NL, 1'b1);
    endtask

    // driver: send characters, predict frames on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin : drv
        frame_t f;
        int r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_char  <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (take_char(rx_char, f))
                begin
                    frame_q.push_back(f);
                end
                send_beats++;
                if (send_beats % 128 == 0)
                begin
                    send_quiet = !send_quiet;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (line_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    stim_done = 1'b1;
                end
                else if (line_q[0].drain)
                begin
                    // hold until every frame is out
                    if (frame_q.size() == 0)
                    begin
                        void'(line_q.pop_front());
                    end
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_char  <= line_q[0].ch;
                    void'(line_q.pop_front());
                    if (send_quiet)
                    begin
                        gap_left = 0;
                    end
                    else
                    begin
                        r = $urandom_range(0, 99);
                        gap_left = (r < 60) ? 0 :
                                   (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    end
                end
            end
        end
    end

    // monitor: check frames, drive out_stall
    always @(posedge clk or negedge rst_n)
    begin : mon
        frame_t want;
        logic [FRAME_BYTES-1:0][7:0] got_data;
        bit start_hold;
        int i;
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            start_hold = 1'b0;
            if (out_valid && !out_stall)
            begin
                got_data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
                if (frame_q.size() == 0)
                begin
                    note_error($sformatf("unexpected frame id %h len %h data %h",
                                         frame_id, frame_len, got_data));
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (frame_id !== want.id)
                    begin
                        note_error($sformatf("frame %0d id: got %h, want %h",
                                             frames_seen, frame_id, want.id));
                    end
                    if (frame_len !== want.len)
                    begin
                        note_error($sformatf("frame %0d len: got %h, want %h",
                                             frames_seen, frame_len, want.len));
                    end
                    for (i = 0; i < FRAME_BYTES; i++)
                    begin
                        if (got_data[i] !== want.data[i])
                        begin
                            note_error($sformatf("frame %0d byte%0d: got %h, want %h",
                                                 frames_seen, i, got_data[i], want.data[i]));
                        end
                    end
                end
                frames_seen++;
                start_hold = (frames_seen == 8 || frames_seen == 25 || frames_seen == 40);
            end
            out_cycles++;
            if (out_cycles % 150 == 0)
            begin
                out_quiet = !out_quiet;
            end
            if (start_hold)
            begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (out_quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_stall <= 1'b0;
                end
                else if (r < 95)
                begin
                    out_stall <= 1'b1;
                    stall_left = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        @(posedge rst_n);
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_run = 0;
            end
            else
            begin
                idle_run++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : run
        int next_drain;
        push_text("\n");
        push_text("t1\n");
        push_text("tAbCtz\n");
        push_text("t7fF8e5\n");
        push_text("t0\r03a\n");
        push_text("tFFFF0123456789abcdefABCDEF\n");
        push_drain();
        next_drain = stim_items + 100;
        while (stim_items < 400)
        begin
            add_line();
            if (stim_items >= next_drain)
            begin
                push_drain();
                next_drain += 100;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!stim_done || frame_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frame_q.size() != 0)
        begin
            note_error($sformatf("%0d frames never arrived", frame_q.size()));
        end
        if (err_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
